// File: rtl/core/kwc_pkg.sv
// Shared types, character codes and keyword table for the keyword word classifier.
package kwc_pkg;

	localparam int OFFSET_BITS = 32;
	localparam int NUM_KW      = 24;

	typedef logic [4:0]             code_t;
	typedef logic [OFFSET_BITS-1:0] offset_t;

	localparam code_t CODE_NUMBER = 5'd8;
	localparam code_t CODE_IDENT  = 5'd9;

	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_NL    = 8'h0A;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// text is right-aligned: the last character sits in the low byte
	typedef struct packed {
		logic [63:0] text;
		logic [3:0]  len;
		code_t       code;
	} kw_entry_t;

	typedef struct packed {
		code_t       code;
		offset_t     start;
		logic [7:0]  length;
	} result_t;

	localparam kw_entry_t KW_TABLE [NUM_KW] = '{
		'{64'("ciao"),     4'd4, 5'd0},
		'{64'("ciaociao"), 4'd8, 5'd1},
		'{64'("int"),      4'd3, 5'd2},
		'{64'("string"),   4'd6, 5'd3},
		'{64'("("),        4'd1, 5'd4},
		'{64'(")"),        4'd1, 5'd5},
		'{64'(":"),        4'd1, 5'd6},
		'{64'("\""),       4'd1, 5'd7},
		'{64'("se"),       4'd2, 5'd10},
		'{64'("oppure"),   4'd6, 5'd11},
		'{64'("PS"),       4'd2, 5'd12},
		'{64'("piu"),      4'd3, 5'd13},
		'{64'("meno"),     4'd4, 5'd14},
		'{64'("per"),      4'd3, 5'd15},
		'{64'("diviso"),   4'd6, 5'd16},
		'{64'("="),        4'd1, 5'd17},
		'{64'("!="),       4'd2, 5'd18},
		'{64'("<"),        4'd1, 5'd19},
		'{64'(">"),        4'd1, 5'd20},
		'{64'("stampa"),   4'd6, 5'd21},
		'{64'("leggi"),    4'd5, 5'd22},
		'{64'("basta"),    4'd5, 5'd23},
		'{64'("e"),        4'd1, 5'd24},
		'{64'("o"),        4'd1, 5'd25}
	};

endpackage

// File: rtl/core/kwc_word_unit.sv
// Word tracker: running keyword match bits, digit flag, counters and token classification.
module kwc_word_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        text_byte,
	input  logic              is_last,
	output logic              emit,
	output kwc_pkg::result_t  result
);

	logic [kwc_pkg::NUM_KW-1:0] match_q;
	logic                       digits_q;
	logic                       in_word_q;
	logic [7:0]                 chars_q;
	kwc_pkg::offset_t           start_q;
	kwc_pkg::offset_t           offset_q;

	logic [kwc_pkg::NUM_KW-1:0] hit;
	logic [kwc_pkg::NUM_KW-1:0] match_t;
	logic                       digits_t;
	logic [7:0]                 chars_t;
	kwc_pkg::offset_t           start_t;
	logic                       in_word_t;
	logic                       sep;
	logic                       close_now;
	kwc_pkg::code_t             code;
	logic                       found;

	always_comb begin
		logic [2:0] idx;
		logic [7:0] kw_char;
		sep = (text_byte == kwc_pkg::CHAR_SPACE) || (text_byte == kwc_pkg::CHAR_TAB) ||
		      (text_byte == kwc_pkg::CHAR_NL);

		for (int k = 0; k < kwc_pkg::NUM_KW; k++) begin
			idx     = 3'(kwc_pkg::KW_TABLE[k].len - 4'd1) - chars_q[2:0];
			kw_char = kwc_pkg::KW_TABLE[k].text[{idx, 3'b000} +: 8];
			hit[k]  = (chars_q < {4'b0000, kwc_pkg::KW_TABLE[k].len}) && (kw_char == text_byte);
		end

		// state after taking the byte in; a separator leaves it untouched
		if (sep) begin
			match_t   = match_q;
			digits_t  = digits_q;
			chars_t   = chars_q;
			start_t   = start_q;
			in_word_t = in_word_q;
		end else begin
			match_t   = match_q & hit;
			digits_t  = digits_q && (text_byte >= kwc_pkg::CHAR_ZERO) &&
			            (text_byte <= kwc_pkg::CHAR_NINE);
			chars_t   = (chars_q == 8'hFF) ? chars_q : chars_q + 8'd1;
			start_t   = in_word_q ? start_q : offset_q;
			in_word_t = 1'b1;
		end

		close_now = (sep || is_last) && in_word_t;

		// lowest table entry wins
		code  = kwc_pkg::CODE_IDENT;
		found = 1'b0;
		for (int k = kwc_pkg::NUM_KW - 1; k >= 0; k--) begin
			if (match_t[k] && (chars_t == {4'b0000, kwc_pkg::KW_TABLE[k].len})) begin
				code  = kwc_pkg::KW_TABLE[k].code;
				found = 1'b1;
			end
		end
		if (!found && digits_t) begin
			code = kwc_pkg::CODE_NUMBER;
		end

		emit          = close_now;
		result.code   = code;
		result.start  = start_t;
		result.length = chars_t;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q   <= '1;
			digits_q  <= 1'b1;
			in_word_q <= 1'b0;
			chars_q   <= '0;
			start_q   <= '0;
			offset_q  <= '0;
		end else if (step) begin
			if (sep || is_last) begin
				match_q   <= '1;
				digits_q  <= 1'b1;
				in_word_q <= 1'b0;
				chars_q   <= '0;
			end else begin
				match_q   <= match_t;
				digits_q  <= digits_t;
				in_word_q <= in_word_t;
				chars_q   <= chars_t;
			end
			start_q  <= start_t;
			offset_q <= is_last ? '0 : offset_q + kwc_pkg::offset_t'(1);
		end
	end

endmodule

// File: rtl/core/keyword_word_classifier_core.sv
// Top level of the keyword word classifier: input register, word unit and result register.
// Takes one text byte per cycle while in_stall is low and gives one token item for each
// whitespace-separated word that a separator or the byte marked last closes. Every byte
// passes an input register, then the match-bit update and classification in the word unit,
// and a token lands in the result register; the sustained rate is one byte a cycle while
// no stall holds the flow. A byte that closes no word moves on even while a
// token waits downstream; a byte that closes a word waits until the result register is free.
module keyword_word_classifier_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        is_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  token_code,
	output logic [31:0] word_start,
	output logic [7:0]  word_length
);

	logic              valid_s1;
	logic [7:0]        text_s1;
	logic              last_s1;
	logic              emit;
	logic              adv;
	logic              step;
	kwc_pkg::result_t  result;
	kwc_pkg::result_t  res_q;
	logic              out_valid_q;

	kwc_word_unit u_word (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.text_byte (text_s1),
		.is_last   (last_s1),
		.emit      (emit),
		.result    (result)
	);

	assign adv      = !emit || !out_valid_q || !out_stall;
	assign step     = valid_s1 && adv;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			text_s1 <= text_byte;
			last_s1 <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			res_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign token_code  = res_q.code;
	assign word_start  = 32'(res_q.start);
	assign word_length = res_q.length;

endmodule

// File: rtl/core/kwc_checker.sv
// Port-level checks for the keyword word classifier and their binding to the top level.
module kwc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [7:0]  text_byte,
	input logic        is_last,
	input logic        out_valid,
	input logic        out_stall,
	input logic [4:0]  token_code,
	input logic [31:0] word_start,
	input logic [7:0]  word_length
);

	// a stalled input item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(text_byte) && $stable(is_last))
		else $error("input item changed while stalled");

	// a stalled token holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_code) &&
		$stable(word_start) && $stable(word_length))
		else $error("token changed while stalled");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> word_length != 8'd0)
		else $error("empty word emitted");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> token_code <= 5'd25)
		else $error("token code out of range");

	// keyword tokens are never longer than the longest keyword
	a_kw_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_code != kwc_pkg::CODE_NUMBER &&
		token_code != kwc_pkg::CODE_IDENT |-> word_length <= 8'd8)
		else $error("keyword token too long");

endmodule

bind keyword_word_classifier_core kwc_checker u_kwc_checker (.*);
